// ===== design/gfau_pkg.sv =====
// Shared types, constants and helper functions for the GF(2^8) arithmetic unit.
// No dependencies; used by gfau_euclid_stage and gf256_arithmetic_unit.
`default_nettype none

package gfau_pkg;

   // Field element and polynomial widths.
   localparam int unsigned DataWidth = 8;
   localparam int unsigned PolyWidth = DataWidth + 1;
   localparam int unsigned ProdWidth = 2 * DataWidth - 1;

   // Reduction polynomial after reset: x^8 + x^4 + x^3 + x + 1.
   localparam logic [PolyWidth-1:0] PolyReset = 9'h11b;

   // One subtraction step per stage; the degree sum of the two remainders
   // starts at 15 at most, so 16 steps always bring one remainder to zero.
   localparam int unsigned EuclidSteps = 16;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_INV = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Operands that ride along with the inverse pipeline.
   typedef struct packed {
      op_type               op;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
   } tag_type;

   // Extended Euclid state: remainders and their Bezout coefficients.
   typedef struct packed {
      logic [PolyWidth-1:0] rp;
      logic [PolyWidth-1:0] r;
      logic [PolyWidth-1:0] tp;
      logic [PolyWidth-1:0] t;
   } euclid_type;

   // Degree of a nonzero polynomial; zero maps to degree 0 and is checked apart.
   function automatic logic [3:0] poly_degree(input logic [PolyWidth-1:0] value);
      logic [3:0] deg;
      deg = '0;
      for (int i = 0; i < PolyWidth; i++) begin
         if (value[i]) begin
            deg = 4'(i);
         end
      end
      return deg;
   endfunction

   // Carry-less product of two field elements.
   function automatic logic [ProdWidth-1:0] clmul(input logic [DataWidth-1:0] x,
                                                  input logic [DataWidth-1:0] y);
      logic [ProdWidth-1:0] acc;
      acc = '0;
      for (int i = 0; i < DataWidth; i++) begin
         if (x[i]) begin
            acc = acc ^ (ProdWidth'(y) << i);
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ===== design/gf256_arithmetic_unit.sv =====
// GF(2^8) arithmetic unit: add, multiply, inverse and divide in a stalling pipeline.
// Depends on gfau_pkg and instantiates gfau_euclid_stage.
`default_nettype none

// Every transaction passes 19 register stages: 16 extended Euclid stages, one
// per leading-term cancellation, then one carry-less multiply stage and two
// modulo-reduction stages, the last of which registers the result. A new
// transaction is accepted every cycle; while a result waits under rsp_stall the
// whole pipeline holds, and req_stall follows. The inverse of zero is zero, so
// division by zero gives zero. Bit 8 of the reduction polynomial is always
// taken as set. Write the polynomial only while the pipeline is empty.
module gf256_arithmetic_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [8:0] csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_a,
   input  wire logic [7:0] req_b,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_result
);

   localparam int unsigned Steps = gfau_pkg::EuclidSteps;
   localparam int unsigned DW    = gfau_pkg::DataWidth;
   localparam int unsigned PW    = gfau_pkg::PolyWidth;
   localparam int unsigned XW    = gfau_pkg::ProdWidth;

   logic                 advance;
   logic [PW-1:0]        poly_ff;
   logic [PW-1:0]        poly_eff;
   logic [XW-1:0]        poly_wide;

   logic                 stage_valid [0:Steps];
   gfau_pkg::tag_type    stage_tag   [0:Steps];
   gfau_pkg::euclid_type stage_state [0:Steps];

   gfau_pkg::tag_type    last_tag;
   gfau_pkg::euclid_type last_state;
   logic [DW-1:0]        inv_value;
   logic [DW-1:0]        mul_operand;

   logic                 m1_valid_ff;
   gfau_pkg::op_type     m1_op_ff;
   logic [XW-1:0]        m1_prod_ff;
   logic [XW-1:0]        m1_prod_in;
   logic [DW-1:0]        m1_direct_ff;
   logic [DW-1:0]        m1_direct_in;

   logic                 m2_valid_ff;
   gfau_pkg::op_type     m2_op_ff;
   logic [XW-1:0]        m2_prod_ff;
   logic [XW-1:0]        m2_prod_in;
   logic [DW-1:0]        m2_direct_ff;

   logic [XW-1:0]        m3_prod;
   logic                 rsp_valid_ff;
   logic [DW-1:0]        rsp_result_ff;
   logic [DW-1:0]        rsp_result_in;

   // The pipeline moves unless a finished result is being held back.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Reduction polynomial register.
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= gfau_pkg::PolyReset;
      end else if (csr_wr_en) begin
         poly_ff <= csr_wr_data;
      end
   end

   assign poly_eff  = {1'b1, poly_ff[PW-2:0]};
   assign poly_wide = XW'(poly_eff);

   // Entry: the inverse works on a, or on b for a division.
   always_comb begin
      stage_valid[0]    = req_valid;
      stage_tag[0].op   = gfau_pkg::op_type'(req_op);
      stage_tag[0].a    = req_a;
      stage_tag[0].b    = req_b;
      stage_state[0].rp = poly_eff;
      stage_state[0].r  = (gfau_pkg::op_type'(req_op) == gfau_pkg::OP_DIV) ?
                          PW'(req_b) : PW'(req_a);
      stage_state[0].tp = '0;
      stage_state[0].t  = PW'(1);
   end

   // Extended Euclid pipeline.
   for (genvar k = 0; k < Steps; k++) begin : g_euclid
      gfau_euclid_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_tag    (stage_tag[k]),
         .in_state  (stage_state[k]),
         .out_valid (stage_valid[k+1]),
         .out_tag   (stage_tag[k+1]),
         .out_state (stage_state[k+1])
      );
   end

   assign last_tag   = stage_tag[Steps];
   assign last_state = stage_state[Steps];

   // If the last remainder reached zero only as a dividend, the closing swap
   // is still pending, so the coefficient is taken from the other slot.
   assign inv_value = (last_state.r == '0) ? last_state.tp[DW-1:0] :
                                             last_state.t[DW-1:0];

   // Multiply stage: carry-less product, and the result of add or inverse.
   always_comb begin
      mul_operand  = (last_tag.op == gfau_pkg::OP_MUL) ? last_tag.b : inv_value;
      m1_prod_in   = gfau_pkg::clmul(last_tag.a, mul_operand);
      m1_direct_in = (last_tag.op == gfau_pkg::OP_ADD) ? (last_tag.a ^ last_tag.b) :
                                                         inv_value;
   end

   // First reduction stage clears the upper product bits.
   always_comb begin
      m2_prod_in = m1_prod_ff;
      for (int i = XW - 1; i >= DW + (XW - DW) / 2; i--) begin
         if (m2_prod_in[i]) begin
            m2_prod_in = m2_prod_in ^ (poly_wide << (i - DW));
         end
      end
   end

   // Second reduction stage clears the rest and picks the result.
   always_comb begin
      m3_prod = m2_prod_ff;
      for (int i = DW + (XW - DW) / 2 - 1; i >= DW; i--) begin
         if (m3_prod[i]) begin
            m3_prod = m3_prod ^ (poly_wide << (i - DW));
         end
      end
      case (m2_op_ff)
         gfau_pkg::OP_MUL: rsp_result_in = m3_prod[DW-1:0];
         gfau_pkg::OP_DIV: rsp_result_in = m3_prod[DW-1:0];
         default:          rsp_result_in = m2_direct_ff;
      endcase
   end

   // Valid bits of the multiply and output stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff  <= stage_valid[Steps];
         m2_valid_ff  <= m1_valid_ff;
         rsp_valid_ff <= m2_valid_ff;
      end
   end

   // Payload of the multiply and output stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         m1_op_ff      <= last_tag.op;
         m1_prod_ff    <= m1_prod_in;
         m1_direct_ff  <= m1_direct_in;
         m2_op_ff      <= m1_op_ff;
         m2_prod_ff    <= m2_prod_in;
         m2_direct_ff  <= m1_direct_ff;
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef SYNTH
   // After the last Euclid stage one of the two remainders must be zero.
   a_euclid_done: assert property (@(posedge clock) disable iff (reset)
      stage_valid[Steps] |-> (last_state.r == '0 || last_state.rp == '0))
      else $error("Euclid pipeline ended with two nonzero remainders");

   // A finished inverse coefficient always fits in one field element.
   a_inverse_width: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[Steps] && last_state.r == '0) |-> (last_state.tp[PW-1] == 1'b0))
      else $error("Inverse coefficient exceeds field width");

   // A transaction leaving the Euclid stages enters the multiply stage.
   a_mul_entry: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_valid[Steps]) |=> m1_valid_ff)
      else $error("Transaction lost between inverse and multiply stages");
`endif

endmodule

`default_nettype wire

// ===== design/gfau_euclid_stage.sv =====
// One registered step of the extended Euclidean algorithm over GF(2)[x].
// Depends on gfau_pkg for the state and tag types and the degree function.
`default_nettype none

module gfau_euclid_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire gfau_pkg::tag_type    in_tag,
   input  wire gfau_pkg::euclid_type in_state,
   output logic                    out_valid,
   output gfau_pkg::tag_type         out_tag,
   output gfau_pkg::euclid_type      out_state
);

   logic                 valid_ff;
   gfau_pkg::tag_type    tag_ff;
   gfau_pkg::euclid_type state_ff;
   gfau_pkg::euclid_type state_in;

   logic                                swap;
   logic [3:0]                          deg_rp;
   logic [3:0]                          deg_r;
   logic [3:0]                          shift_amt;
   logic [gfau_pkg::PolyWidth-1:0]      rem_a;
   logic [gfau_pkg::PolyWidth-1:0]      rem_b;
   logic [gfau_pkg::PolyWidth-1:0]      coef_a;
   logic [gfau_pkg::PolyWidth-1:0]      coef_b;

   // When the dividend has dropped below the divisor the two swap roles, which
   // closes one polynomial division; then the leading term is cancelled once.
   always_comb begin
      deg_rp    = gfau_pkg::poly_degree(in_state.rp);
      deg_r     = gfau_pkg::poly_degree(in_state.r);
      swap      = (in_state.rp == '0) || (deg_rp < deg_r);
      rem_a     = swap ? in_state.r  : in_state.rp;
      rem_b     = swap ? in_state.rp : in_state.r;
      coef_a    = swap ? in_state.t  : in_state.tp;
      coef_b    = swap ? in_state.tp : in_state.t;
      shift_amt = swap ? (deg_r - deg_rp) : (deg_rp - deg_r);
      state_in  = in_state;
      if (in_state.r != '0) begin
         state_in.rp = rem_a;
         state_in.r  = rem_b;
         state_in.tp = coef_a;
         state_in.t  = coef_b;
         if (rem_b != '0) begin
            state_in.rp = rem_a ^ (rem_b << shift_amt);
            state_in.tp = coef_a ^ (coef_b << shift_amt);
         end
      end
   end

   // Stage register; the whole pipeline holds while the result is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff   <= in_tag;
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_state = state_ff;

endmodule

`default_nettype wire

// ===== tb/tb_gf256_arithmetic_unit.sv =====
// Self-checking testbench for gf256_arithmetic_unit: add, multiply, inverse and divide.
// Depends on gfau_pkg for the operation codes and the reset polynomial.
`default_nettype none

module tb_gf256_arithmetic_unit;

   // One expected transaction on the result channel, with its operands for messages.
   typedef struct {
      gfau_pkg::op_type op;
      logic [7:0]       a;
      logic [7:0]       b;
      logic [7:0]       result;
   } field_outcome_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [8:0] csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = '0;
   logic [7:0] req_a = '0;
   logic [7:0] req_b = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_result;

   // Predictor copy of the polynomial register and the results still awaited.
   logic [8:0]        poly_setting = gfau_pkg::PolyReset;
   field_outcome_type awaited_results[$];
   int                error_count = 0;

   // Idle rates in percent and the long receiver hold-off request.
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_request = 1'b0;
   int hold_count = 0;

   gf256_arithmetic_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_a       (req_a),
      .req_b       (req_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Carry-less product of two polynomials below degree 16.
   function automatic logic [31:0] cl_product(input logic [15:0] x, input logic [15:0] y);
      logic [31:0] acc;
      acc = '0;
      for (int i = 0; i < 16; i++) begin
         if (x[i]) begin
            acc = acc ^ ({16'd0, y} << i);
         end
      end
      return acc;
   endfunction

   // Polynomial long division over GF(2); returns the quotient, remainder in rem.
   function automatic logic [15:0] poly_divide(input logic [15:0] num, input logic [15:0] den,
                                               output logic [15:0] rem);
      logic [15:0] quot;
      int          den_deg;
      quot = '0;
      den_deg = -1;
      rem = num;
      for (int i = 0; i < 16; i++) begin
         if (den[i]) begin
            den_deg = i;
         end
      end
      for (int i = 15; i >= 0; i--) begin
         if (den_deg >= 0 && i >= den_deg && rem[i]) begin
            quot[i - den_deg] = 1'b1;
            rem = rem ^ (den << (i - den_deg));
         end
      end
      return quot;
   endfunction

   // Bit 8 of the polynomial is always taken as set.
   function automatic logic [15:0] active_poly();
      return {7'd0, 1'b1, poly_setting[7:0]};
   endfunction

   function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
      logic [31:0] wide;
      logic [15:0] quot;
      logic [15:0] rem;
      wide = cl_product({8'd0, x}, {8'd0, y});
      quot = poly_divide(wide[15:0], active_poly(), rem);
      return rem[7:0];
   endfunction

   // Extended Euclid; the Bezout coefficient is kept even for a reducible polynomial,
   // and zero maps to zero.
   function automatic logic [7:0] field_inverse(input logic [7:0] x);
      logic [15:0] r_prev;
      logic [15:0] r_cur;
      logic [15:0] t_prev;
      logic [15:0] t_cur;
      logic [15:0] quot;
      logic [15:0] rem;
      logic [31:0] wide;
      r_prev = active_poly();
      r_cur = {8'd0, x};
      t_prev = '0;
      t_cur = 16'd1;
      for (int n = 0; n < 12 && r_cur != 0; n++) begin
         quot = poly_divide(r_prev, r_cur, rem);
         wide = cl_product(quot, t_cur);
         r_prev = r_cur;
         r_cur = rem;
         wide = {16'd0, t_prev ^ wide[15:0]};
         t_prev = t_cur;
         t_cur = wide[15:0];
      end
      return t_prev[7:0];
   endfunction

   function automatic logic [7:0] predict_result(input gfau_pkg::op_type op,
                                                 input logic [7:0] a,
                                                 input logic [7:0] b);
      case (op)
         gfau_pkg::OP_ADD: return a ^ b;
         gfau_pkg::OP_MUL: return field_product(a, b);
         gfau_pkg::OP_INV: return field_inverse(a);
         default: return field_product(a, field_inverse(b));
      endcase
   endfunction

   task automatic report_mismatch(input string text);
      $display("ERROR at %0t: %s", $time, text);
      error_count++;
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_count = 300;
         hold_request = 1'b0;
      end
      if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count = hold_count - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      field_outcome_type exp_item;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %02h", rsp_result));
         end else begin
            exp_item = awaited_results.pop_front();
            if (rsp_result !== exp_item.result) begin
               report_mismatch($sformatf(
                  "%s a=%02h b=%02h poly=%03h: result %02h, expected %02h",
                  exp_item.op.name(), exp_item.a, exp_item.b, poly_setting, rsp_result,
                  exp_item.result));
            end
         end
      end
   end

   // Offer one transaction, possibly after random idle cycles; returns at a falling edge.
   task automatic send_item(input gfau_pkg::op_type op, input logic [7:0] a,
                            input logic [7:0] b);
      field_outcome_type item;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_a <= a;
      req_b <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      item.op = op;
      item.a = a;
      item.b = b;
      item.result = predict_result(op, a, b);
      awaited_results.push_back(item);
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_idle();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (awaited_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_poly(input logic [8:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      poly_setting = value;
   endtask

   // Operands biased toward the corner values.
   function automatic logic [7:0] pick_operand();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'hff;
         3: return 8'h80;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_items(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(gfau_pkg::op_type'($urandom_range(3)), pick_operand(), pick_operand());
      end
   endtask

   // Corner operands for every operation under the reset polynomial.
   task automatic test_directed_ops();
      send_item(gfau_pkg::OP_ADD, 8'h00, 8'h00);
      send_item(gfau_pkg::OP_ADD, 8'hff, 8'hff);
      send_item(gfau_pkg::OP_ADD, 8'ha5, 8'h5a);
      send_item(gfau_pkg::OP_MUL, 8'h00, 8'h9c);
      send_item(gfau_pkg::OP_MUL, 8'h01, 8'h37);
      send_item(gfau_pkg::OP_MUL, 8'hff, 8'hff);
      send_item(gfau_pkg::OP_MUL, 8'h53, 8'hca);
      send_item(gfau_pkg::OP_MUL, 8'h80, 8'h80);
      send_item(gfau_pkg::OP_INV, 8'h00, 8'hff);
      send_item(gfau_pkg::OP_INV, 8'h01, 8'h00);
      send_item(gfau_pkg::OP_INV, 8'hff, 8'h12);
      send_item(gfau_pkg::OP_INV, 8'h53, 8'h00);
      send_item(gfau_pkg::OP_INV, 8'h80, 8'haa);
      send_item(gfau_pkg::OP_DIV, 8'h37, 8'h00);
      send_item(gfau_pkg::OP_DIV, 8'h00, 8'h00);
      send_item(gfau_pkg::OP_DIV, 8'h00, 8'h5e);
      send_item(gfau_pkg::OP_DIV, 8'hff, 8'hff);
      send_item(gfau_pkg::OP_DIV, 8'h01, 8'h53);
      send_item(gfau_pkg::OP_DIV, 8'hca, 8'h01);
      wait_idle();
   endtask

   // Hold the result channel for a long stretch while the sender keeps offering.
   task automatic test_backpressure();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 1'b1;
      send_random_items(60);
      wait_idle();
   endtask

   // Several polynomials, the extremes among them: bit 8 clear, x^8 alone, all ones.
   task automatic test_poly_settings();
      logic [8:0] settings[6];
      settings = '{9'h01b, 9'h100, 9'h1ff, 9'h000, 9'h11d, 9'($urandom_range(511))};
      foreach (settings[k]) begin
         write_poly(settings[k]);
         send_item(gfau_pkg::OP_INV, 8'h00, 8'h00);
         send_item(gfau_pkg::OP_INV, 8'h01, 8'hff);
         send_item(gfau_pkg::OP_INV, 8'hff, 8'h00);
         send_item(gfau_pkg::OP_INV, 8'h02, 8'h00);
         send_item(gfau_pkg::OP_DIV, 8'hff, 8'h00);
         send_item(gfau_pkg::OP_MUL, 8'hff, 8'hff);
         send_random_items(30);
      end
      write_poly(gfau_pkg::PolyReset);
   endtask

   task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct,
                                      input logic [8:0] poly);
      write_poly(poly);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      send_random_items(count);
      wait_idle();
   endtask

   // Main sequence.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      req_gap_pct = 21;
      rsp_stall_pct = 59;
      test_directed_ops();
      test_poly_settings();
      test_backpressure();
      test_random_traffic(220, 21, 59, gfau_pkg::PolyReset);
      test_random_traffic(220, 59, 21, 9'h11d);
      test_random_traffic(220, 0, 0, 9'($urandom_range(256, 511)));
      wait_idle();
      repeat (30) @(negedge clock);
      if (error_count == 0) begin
         $display("gf256_arithmetic_unit test passed");
      end else begin
         $display("gf256_arithmetic_unit test failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("gf256_arithmetic_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire
